// ----- src/osem_pkg.sv -----
// ---------------------------------------------------------------------------
// osem_pkg
// Shared types and constants for the owned semaphore with wait queue.
// ---------------------------------------------------------------------------
package osem_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int TOTAL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int COUNT_W     = 16;
    localparam int CFG_W       = 8;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7fff;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

    localparam logic [CFG_W-1:0]   INITIAL_COUNT_RESET = 8'd1;
    localparam logic [PADDR_W-1:0] ADDR_INITIAL_COUNT  = 3'd0;

    localparam logic MODE_ACQUIRE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [1:0] STATUS_AVAILABLE = 2'd0;
    localparam logic [1:0] STATUS_BUSY      = 2'd1;
    localparam logic [1:0] STATUS_ACQUIRED  = 2'd2;

    typedef struct packed {
        logic            mode;
        logic [ID_W-1:0] task_id;
    } request_t;

    typedef struct packed {
        logic [1:0]      status;
        logic            suspend_task;
        logic            wake_valid;
        logic [ID_W-1:0] wake_task_id;
        logic            queue_error;
    } result_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } cmd_t;

endpackage

// ----- src/owned_semaphore_with_wait_fifo.sv -----
// ---------------------------------------------------------------------------
// owned_semaphore_with_wait_fifo
// Counting semaphore with an owner and a FIFO of waiting task ids.
// ---------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. The
// capture step reads the head of the wait queue from its memory (registered
// read port), then the update step changes count, owner and queue and loads
// the result register. The result then sits on the result ports for exactly
// one cycle with done high; the receiver cannot stall it, so it must take
// every result in that cycle. busy is low again in the cycle the result is
// shown, so a new request may be issued then; no new request is taken while
// one is being updated. The wait queue needs no clearing pass after reset:
// writing initial_count reloads the count and empties the queue and the
// owner at once. Write configuration only while no request is in flight.
// ---------------------------------------------------------------------------
module owned_semaphore_with_wait_fifo (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             start,
    output logic                             busy,
    input  osem_pkg::request_t               request,
    // result channel
    output logic                             done,
    output osem_pkg::result_t                result,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [osem_pkg::PADDR_W-1:0]     paddr,
    input  logic [osem_pkg::PDATA_W-1:0]     pwdata,
    output logic [osem_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    osem_pkg::cmd_t                 cmd;
    logic [osem_pkg::CFG_W-1:0]     initial_count_reg;
    logic                           cfg_write;
    logic                           reload;

    // Register write completes in the access phase; pready never stalls.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reload    = cfg_write && (paddr == osem_pkg::ADDR_INITIAL_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_count_reg <= osem_pkg::INITIAL_COUNT_RESET;
        end
        else if (reload)
        begin
            initial_count_reg <= pwdata[osem_pkg::CFG_W-1:0];
        end
    end

    // Read back the only register; other addresses read as zero.
    assign prdata = (paddr == osem_pkg::ADDR_INITIAL_COUNT)
                    ? osem_pkg::PDATA_W'(initial_count_reg) : '0;

    // Sequencer: capture the request, then run its update.
    osem_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Datapath: count, owner, wait queue and result register. The reload
    // uses the incoming write data so the count follows the new value.
    osem_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .request       (request),
        .reload        (reload),
        .initial_count (pwdata[osem_pkg::CFG_W-1:0]),
        .done          (done),
        .result        (result)
    );

endmodule

// ----- src/osem_ram.sv -----
// ---------------------------------------------------------------------------
// osem_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module osem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/osem_ctrl.sv -----
// ---------------------------------------------------------------------------
// osem_ctrl
// Request sequencer: capture a request, then run its update cycle.
// ---------------------------------------------------------------------------
module osem_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output osem_pkg::cmd_t cmd
);

    localparam logic STATE_IDLE = 1'b0;
    localparam logic STATE_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            STATE_IDLE:
            begin
                if (start)
                begin
                    state_next = STATE_EXEC;
                end
            end
            STATE_EXEC:
            begin
                state_next = STATE_IDLE;
            end
            default:
            begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy        = (state_reg == STATE_EXEC);
    assign cmd.capture = start && (state_reg == STATE_IDLE);
    assign cmd.exec    = (state_reg == STATE_EXEC);

endmodule

// ----- src/osem_datapath.sv -----
// ---------------------------------------------------------------------------
// osem_datapath
// Count, owner, wait queue pointers and result register.
// ---------------------------------------------------------------------------
module osem_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  osem_pkg::cmd_t                 cmd,
    input  osem_pkg::request_t             request,
    input  logic                           reload,
    input  logic [osem_pkg::CFG_W-1:0]     initial_count,
    output logic                           done,
    output osem_pkg::result_t              result
);

    osem_pkg::request_t req_reg;

    logic signed [osem_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [osem_pkg::ID_W-1:0]           owner_reg, owner_next;
    logic [osem_pkg::TOTAL_W-1:0]        total_reg, total_next;
    logic [osem_pkg::PTR_W-1:0]          head_reg, head_next;
    logic [osem_pkg::PTR_W-1:0]          tail_reg, tail_next;
    osem_pkg::result_t                   result_reg, result_next;
    logic                                done_reg;

    logic                                push;
    logic [osem_pkg::ID_W-1:0]           head_data;
    logic signed [osem_pkg::COUNT_W-1:0] count_dec, count_inc;

    osem_ram #(
        .WIDTH (osem_pkg::ID_W),
        .DEPTH (osem_pkg::QUEUE_DEPTH)
    ) u_wait_ram (
        .clk   (clk),
        .we    (push),
        .waddr (tail_reg),
        .wdata (req_reg.task_id),
        .re    (cmd.capture),
        .raddr (head_reg),
        .rdata (head_data)
    );

    assign count_dec = (count_reg > osem_pkg::COUNT_MIN) ? count_reg - 16'sd1
                                                         : osem_pkg::COUNT_MIN;
    assign count_inc = (count_reg < osem_pkg::COUNT_MAX) ? count_reg + 16'sd1
                                                         : osem_pkg::COUNT_MAX;

    always_comb
    begin
        count_next  = count_reg;
        owner_next  = owner_reg;
        total_next  = total_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        push        = 1'b0;
        result_next = '0;
        result_next.status = osem_pkg::STATUS_AVAILABLE;

        if (req_reg.mode == osem_pkg::MODE_ACQUIRE)
        begin
            if (req_reg.task_id == owner_reg)
            begin
                result_next.status = osem_pkg::STATUS_ACQUIRED;
            end
            else if (count_dec < 0 && owner_reg != '0)
            begin
                result_next.status = osem_pkg::STATUS_BUSY;
                if (total_reg >= osem_pkg::TOTAL_W'(osem_pkg::QUEUE_DEPTH))
                begin
                    result_next.queue_error = 1'b1;
                end
                else
                begin
                    count_next = count_dec;
                    push       = cmd.exec;
                    tail_next  = (tail_reg == osem_pkg::PTR_W'(osem_pkg::QUEUE_DEPTH - 1))
                                 ? '0 : tail_reg + osem_pkg::PTR_W'(1);
                    total_next = total_reg + osem_pkg::TOTAL_W'(1);
                    result_next.suspend_task = 1'b1;
                end
            end
            else
            begin
                count_next = count_dec;
                owner_next = req_reg.task_id;
            end
        end
        else
        begin
            count_next = count_inc;
            if (count_inc <= 0)
            begin
                if (total_reg == '0)
                begin
                    result_next.queue_error = 1'b1;
                end
                else
                begin
                    head_next  = (head_reg == osem_pkg::PTR_W'(osem_pkg::QUEUE_DEPTH - 1))
                                 ? '0 : head_reg + osem_pkg::PTR_W'(1);
                    total_next = total_reg - osem_pkg::TOTAL_W'(1);
                    owner_next = head_data;
                    result_next.wake_valid   = 1'b1;
                    result_next.wake_task_id = head_data;
                end
            end
            else
            begin
                result_next.status = osem_pkg::STATUS_BUSY;
            end
        end
    end

    // hold the request for the update cycle and load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= osem_pkg::COUNT_W'(osem_pkg::INITIAL_COUNT_RESET);
            owner_reg <= '0;
            total_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec;
            priority if (reload)
            begin
                count_reg <= osem_pkg::COUNT_W'(initial_count);
                owner_reg <= '0;
                total_reg <= '0;
                head_reg  <= '0;
                tail_reg  <= '0;
            end
            else if (cmd.exec)
            begin
                count_reg <= count_next;
                owner_reg <= owner_next;
                total_reg <= total_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- bench/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the owned semaphore with a FIFO wait queue.
// ---------------------------------------------------------------------------
// Requests go in through the start/busy command port. Results are taken from
// the done strobe. A scoreboard class tracks count, owner and wait queue in
// step with each accepted request and checks every result field by field.
// The run covers directed corner cases, a queue overflow and drain, and
// random traffic under several initial counts.
// ---------------------------------------------------------------------------
module tb_top;

    // -----------------------------------------------------------------------
    // Scoreboard: tracks the semaphore and holds the expected results
    // -----------------------------------------------------------------------
    class sem_tracker;
        logic signed [osem_pkg::COUNT_W-1:0] count;
        logic [osem_pkg::ID_W-1:0]           owner;
        int                                  waiters;
        int                                  head;
        int                                  tail;
        logic [osem_pkg::ID_W-1:0]           wait_ids [osem_pkg::QUEUE_DEPTH];
        osem_pkg::result_t                   pending [$];
        int                                  errors;

        function new();
            errors = 0;
            load_count(osem_pkg::INITIAL_COUNT_RESET);
        endfunction

        // A write of initial_count reloads the count and empties owner and queue.
        function void load_count(logic [osem_pkg::CFG_W-1:0] value);
            count   = $signed({{(osem_pkg::COUNT_W-osem_pkg::CFG_W){1'b0}}, value});
            owner   = '0;
            waiters = 0;
            head    = 0;
            tail    = 0;
        endfunction

        // Work out the result of one accepted request and queue it.
        function void note_request(osem_pkg::request_t req);
            osem_pkg::result_t                   res;
            logic signed [osem_pkg::COUNT_W-1:0] next_count;
            res = '0;
            if (req.mode == osem_pkg::MODE_ACQUIRE)
            begin
                if (req.task_id == owner)
                begin
                    // Owner asking again, or id zero while nobody owns it.
                    res.status = osem_pkg::STATUS_ACQUIRED;
                end
                else
                begin
                    next_count = (count != osem_pkg::COUNT_MIN) ? count - 1
                                                                : osem_pkg::COUNT_MIN;
                    if (next_count < 0 && owner != '0)
                    begin
                        res.status = osem_pkg::STATUS_BUSY;
                        if (waiters >= osem_pkg::QUEUE_DEPTH)
                        begin
                            // Full queue: drop the request, keep the count.
                            res.queue_error = 1'b1;
                        end
                        else
                        begin
                            count            = next_count;
                            wait_ids[tail]   = req.task_id;
                            tail             = (tail + 1) % osem_pkg::QUEUE_DEPTH;
                            waiters++;
                            res.suspend_task = 1'b1;
                        end
                    end
                    else
                    begin
                        count      = next_count;
                        owner      = req.task_id;
                        res.status = osem_pkg::STATUS_AVAILABLE;
                    end
                end
            end
            else
            begin
                count = (count != osem_pkg::COUNT_MAX) ? count + 1 : osem_pkg::COUNT_MAX;
                if (count <= 0)
                begin
                    res.status = osem_pkg::STATUS_AVAILABLE;
                    if (waiters == 0)
                    begin
                        res.queue_error = 1'b1;
                    end
                    else
                    begin
                        res.wake_task_id = wait_ids[head];
                        res.wake_valid   = 1'b1;
                        owner            = wait_ids[head];
                        head             = (head + 1) % osem_pkg::QUEUE_DEPTH;
                        waiters--;
                    end
                end
                else
                begin
                    res.status = osem_pkg::STATUS_BUSY;
                end
            end
            pending.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        // Check one result against the oldest expectation.
        function void check_result(osem_pkg::result_t got);
            osem_pkg::result_t want;
            if (pending.size() == 0)
            begin
                $error("result with no request outstanding: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("status",       8'(want.status),       8'(got.status));
            compare_field("suspend_task", 8'(want.suspend_task), 8'(got.suspend_task));
            compare_field("wake_valid",   8'(want.wake_valid),   8'(got.wake_valid));
            compare_field("wake_task_id", want.wake_task_id,     got.wake_task_id);
            compare_field("queue_error",  8'(want.queue_error),  8'(got.queue_error));
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Signals; every input starts at a known value
    // -----------------------------------------------------------------------
    logic                             clk     = 1'b0;
    logic                             rst_n   = 1'b0;
    logic                             start   = 1'b0;
    logic                             busy;
    osem_pkg::request_t               request = '0;
    logic                             done;
    osem_pkg::result_t                result;
    logic                             psel    = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite  = 1'b0;
    logic [osem_pkg::PADDR_W-1:0]     paddr   = '0;
    logic [osem_pkg::PDATA_W-1:0]     pwdata  = '0;
    logic [osem_pkg::PDATA_W-1:0]     prdata;
    logic                             pready;

    sem_tracker tracker = new();

    owned_semaphore_with_wait_fifo i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Take every result in its single strobe cycle; values seen here are the
    // ones present just before the edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            tracker.check_result(result);
        end
    end

    // -----------------------------------------------------------------------
    // Drive tasks
    // -----------------------------------------------------------------------

    // Present one request and hold it until the block takes it. Leave start
    // high on return so a following request can go back to back.
    task automatic send(input logic mode, input logic [osem_pkg::ID_W-1:0] id);
        osem_pkg::request_t req;
        req.mode    = mode;
        req.task_id = id;
        start   <= 1'b1;
        request <= req;
        do @(posedge clk); while (busy !== 1'b0);
        tracker.note_request(req);
    endtask

    // Drop start for a burst of cycles.
    task automatic idle(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop start and hold off until every expected result has come back,
    // then let the pipeline go quiet before returning.
    task automatic drain();
        start <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write of initial_count: setup cycle, then access until pready.
    task automatic write_initial_count(input logic [osem_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= osem_pkg::ADDR_INITIAL_COUNT;
        pwdata  <= {{(osem_pkg::PDATA_W-osem_pkg::CFG_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.load_count(value);
    endtask

    // Pick an id: mostly a small pool so owners repeat, some zero, some wide.
    function automatic logic [osem_pkg::ID_W-1:0] pick_id();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return osem_pkg::ID_W'($urandom_range(1, 6));
        else if (roll == 6)
            return '0;
        else
            return osem_pkg::ID_W'($urandom_range(0, 255));
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        logic [osem_pkg::CFG_W-1:0] settings [6];
        int                         quiet;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset count is one, nobody owns the semaphore.
        send(osem_pkg::MODE_ACQUIRE, 8'd0);       // zero id matches the empty owner
        send(osem_pkg::MODE_ACQUIRE, 8'd5);       // take ownership, count to zero
        send(osem_pkg::MODE_ACQUIRE, 8'd5);       // owner asks again
        send(osem_pkg::MODE_ACQUIRE, 8'd255);     // queued
        send(osem_pkg::MODE_ACQUIRE, 8'd1);       // queued
        send(osem_pkg::MODE_ACQUIRE, 8'd0);       // zero id queued behind an owner
        send(osem_pkg::MODE_RELEASE, 8'd0);       // wake 255
        send(osem_pkg::MODE_RELEASE, 8'd170);     // wake 1, id ignored on release
        send(osem_pkg::MODE_RELEASE, 8'd255);     // wake the zero id, owner becomes none
        send(osem_pkg::MODE_RELEASE, 8'd0);       // count positive again
        send(osem_pkg::MODE_ACQUIRE, 8'd128);
        send(osem_pkg::MODE_RELEASE, 8'd85);
        drain();

        // Count zero: the first release finds no waiter.
        write_initial_count(8'd0);
        send(osem_pkg::MODE_ACQUIRE, 8'd170);
        send(osem_pkg::MODE_RELEASE, 8'd0);       // empty queue on release
        send(osem_pkg::MODE_RELEASE, 8'd0);
        send(osem_pkg::MODE_ACQUIRE, 8'd85);
        drain();

        write_initial_count(8'd255);
        send(osem_pkg::MODE_ACQUIRE, 8'd85);
        send(osem_pkg::MODE_ACQUIRE, 8'd51);      // plenty of count, owner just moves
        send(osem_pkg::MODE_RELEASE, 8'd255);
        drain();

        // Fill the wait queue to overflow, then drain it past empty.
        write_initial_count(8'd0);
        send(osem_pkg::MODE_ACQUIRE, 8'd1);
        while (tracker.waiters < osem_pkg::QUEUE_DEPTH)
        begin
            send(osem_pkg::MODE_ACQUIRE, osem_pkg::ID_W'($urandom_range(2, 255)));
            if ($urandom_range(0, 7) == 0)
                idle($urandom_range(1, 9));
        end
        repeat (3) send(osem_pkg::MODE_ACQUIRE, osem_pkg::ID_W'($urandom_range(2, 255)));
        while (tracker.waiters > 0)
        begin
            send(osem_pkg::MODE_RELEASE, osem_pkg::ID_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0)
                idle($urandom_range(1, 9));
        end
        repeat (2) send(osem_pkg::MODE_RELEASE, osem_pkg::ID_W'($urandom_range(0, 255)));
        drain();

        // Random traffic under several initial counts; the last stretch runs
        // without gaps.
        settings[0] = 8'd0;
        settings[1] = 8'd1;
        settings[2] = 8'd2;
        settings[3] = 8'd255;
        settings[4] = osem_pkg::CFG_W'($urandom_range(0, 255));
        settings[5] = 8'd3;
        quiet = 0;
        foreach (settings[s])
        begin
            write_initial_count(settings[s]);
            for (int n = 0; n < 80; n++)
            begin
                // Re-pick every so often whether this stretch runs without gaps.
                if (n % 25 == 0)
                    quiet = (s == 5) || ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) < 55)
                    send(osem_pkg::MODE_ACQUIRE, pick_id());
                else
                    send(osem_pkg::MODE_RELEASE, osem_pkg::ID_W'($urandom_range(0, 255)));
                if ((s == 2 && n == 60) || (!quiet && $urandom_range(0, 59) == 0))
                    drain();
                else if (!quiet && $urandom_range(0, 3) == 0)
                    idle($urandom_range(1, 9));
            end
            drain();
        end
        repeat (8) @(posedge clk);

        if (tracker.errors == 0 && tracker.pending.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial
    begin
        #10000000;
        $display("Verification failed");
        $finish;
    end

endmodule
